@@ hdl/smrg_pkg.sv @@
// Shared types and constants for the softmax row gradient unit.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none

package smrg_pkg;

    // Row capacity of the element store.
    localparam int MAX_ROW = 16;

    // Store index and fill count widths.
    localparam int IDX_W = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
    localparam int CNT_W = $clog2(MAX_ROW + 1);

    // Field widths.
    localparam int PROB_W = 16;
    localparam int GRAD_W = 16;
    localparam int RAM_W  = PROB_W + GRAD_W;

    // Arithmetic widths: dy*y product, Q13.27 accumulator, difference,
    // split partial products and the rounded sum.
    localparam int PROD_W = PROB_W + GRAD_W + 1;
    localparam int ACC_W  = 40;
    localparam int DIFF_W = ACC_W + 1;
    localparam int LO_W   = 24;
    localparam int HI_W   = DIFF_W - LO_W;
    localparam int PPLO_W = PROB_W + LO_W;
    localparam int PPHI_W = PROB_W + 1 + HI_W;
    localparam int SUM_W  = PPHI_W + LO_W + 1;
    localparam int SHIFT  = 30;
    localparam int Q_W    = SUM_W - SHIFT;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_READ,
        ST_DIFF,
        ST_MUL,
        ST_SUM,
        ST_PUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             store_en;
        logic [IDX_W-1:0] wr_addr;
        logic             acc_clear;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             diff_en;
        logic             mul_en;
        logic             sum_en;
        logic             out_load;
        logic             out_last;
        logic             out_ovf;
    } cmd_t;

endpackage

`default_nettype wire

@@ hdl/smrg_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
`default_nettype none

module smrg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                         clk,
    input  wire logic                                         wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                             wr_data,
    input  wire logic                                         rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/smrg_ctrl.sv @@
// Controller of the softmax row gradient unit: row loading, fill count,
// overflow flag, emission sequencing and the output valid. Uses smrg_pkg.
`default_nettype none

module smrg_ctrl
    import smrg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic row_end,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    output cmd_t      cmd
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;

    logic in_accept;
    logic has_room;
    logic is_last;
    logic out_free;

    assign in_accept = in_valid && (state_reg == ST_LOAD);
    assign has_room  = (fill_reg < CNT_W'(MAX_ROW));
    assign is_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == fill_reg);
    assign out_free  = !out_valid_reg || !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_accept && row_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_READ;
            ST_READ:  state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_PUT;
            ST_PUT:
            begin
                if (out_free)
                begin
                    state_next = is_last ? ST_LOAD : ST_READ;
                end
            end
            default:  state_next = ST_LOAD;
        endcase
    end

    // Outputs toward the datapath and the input channel.
    always_comb
    begin
        cmd           = '0;
        cmd.wr_addr   = fill_reg[IDX_W-1:0];
        cmd.rd_addr   = idx_reg;
        cmd.out_last  = is_last;
        cmd.out_ovf   = ovf_reg;
        in_stall      = 1'b1;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_stall     = 1'b0;
                cmd.store_en = in_accept && has_room;
            end
            ST_DRAIN: cmd.rd_en   = 1'b0;
            ST_READ:  cmd.rd_en   = 1'b1;
            ST_DIFF:  cmd.diff_en = 1'b1;
            ST_MUL:   cmd.mul_en  = 1'b1;
            ST_SUM:   cmd.sum_en  = 1'b1;
            ST_PUT:
            begin
                cmd.out_load  = out_free;
                cmd.acc_clear = out_free && is_last;
            end
            default:  cmd = '0;
        endcase
    end

    // Counters, overflow flag and output valid.
    always_comb
    begin
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        if (in_accept)
        begin
            if (has_room)
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            if (is_last)
            begin
                fill_next = '0;
                ovf_next  = 1'b0;
                idx_next  = '0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_ROW))
        else $error("fill count beyond row capacity");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (fill_reg == CNT_W'(MAX_ROW)))
        else $error("overflow flagged while the store has room");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (CNT_W'(idx_reg) < fill_reg))
        else $error("emission index beyond stored elements");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten while held");

    a_row_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && row_end) |=> (state_reg == ST_DRAIN))
        else $error("row end did not start emission");
`endif

endmodule

`default_nettype wire

@@ hdl/smrg_dp.sv @@
// Datapath of the softmax row gradient unit: element store, dot-product
// accumulator, gradient arithmetic and output registers. Uses smrg_pkg, smrg_ram.
`default_nettype none

module smrg_dp
    import smrg_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmd_t                     cmd,
    input  wire logic [PROB_W-1:0]        prob,
    input  wire logic signed [GRAD_W-1:0] grad_in,
    output logic signed [GRAD_W-1:0]      grad_out,
    output logic                          last_out,
    output logic                          row_overflow
);

    logic [RAM_W-1:0] rd_data;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     prod_en_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic [PROB_W-1:0]        y_reg;
    logic [PPLO_W-1:0]        pplo_reg, pplo_next;
    logic signed [PPHI_W-1:0] pphi_reg, pphi_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [GRAD_W-1:0] grad_out_reg, grad_out_next;
    logic                     last_out_reg;
    logic                     row_overflow_reg;

    logic [PROB_W-1:0]        rd_prob;
    logic [GRAD_W-1:0]        rd_grad;
    logic [LO_W-1:0]          diff_lo;
    logic signed [HI_W-1:0]   diff_hi;
    logic signed [Q_W-1:0]    q;

    smrg_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_ROW)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.store_en),
        .wr_addr (cmd.wr_addr),
        .wr_data ({prob, grad_in}),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_data)
    );

    assign rd_prob = rd_data[RAM_W-1:GRAD_W];
    assign rd_grad = rd_data[GRAD_W-1:0];
    assign diff_lo = diff_reg[LO_W-1:0];
    assign diff_hi = diff_reg[DIFF_W-1:LO_W];

    always_comb
    begin
        prod_next = $signed({1'b0, prob}) * grad_in;
        acc_next  = acc_reg
                  + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        // d = dy * 2^15 - s, both in Q.27.
        diff_next = $signed({{(DIFF_W-GRAD_W-15){rd_grad[GRAD_W-1]}}, rd_grad, 15'b0})
                  - {{(DIFF_W-ACC_W){acc_reg[ACC_W-1]}}, acc_reg};
        // y * d is split into an unsigned low and a signed high partial product.
        pplo_next = y_reg * diff_lo;
        pphi_next = $signed({1'b0, y_reg}) * diff_hi;
        sum_next  = $signed({{(SUM_W-PPHI_W-LO_W){pphi_reg[PPHI_W-1]}}, pphi_reg,
                             {LO_W{1'b0}}})
                  + $signed({{(SUM_W-PPLO_W){1'b0}}, pplo_reg})
                  + $signed(SUM_W'(64'd1 << (SHIFT - 1)));
        // Arithmetic shift gives the floor; then saturate to 16 bits.
        q = sum_reg[SUM_W-1:SHIFT];
        if (q[Q_W-1:GRAD_W-1] == {(Q_W-GRAD_W+1){q[Q_W-1]}})
        begin
            grad_out_next = q[GRAD_W-1:0];
        end
        else if (q[Q_W-1])
        begin
            grad_out_next = {1'b1, {(GRAD_W-1){1'b0}}};
        end
        else
        begin
            grad_out_next = {1'b0, {(GRAD_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_en_reg <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            prod_en_reg <= cmd.store_en;
            if (cmd.acc_clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_en_reg)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.diff_en)
        begin
            diff_reg <= diff_next;
            y_reg    <= rd_prob;
        end
        if (cmd.mul_en)
        begin
            pplo_reg <= pplo_next;
            pphi_reg <= pphi_next;
        end
        if (cmd.sum_en)
        begin
            sum_reg <= sum_next;
        end
        if (cmd.out_load)
        begin
            grad_out_reg     <= grad_out_next;
            last_out_reg     <= cmd.out_last;
            row_overflow_reg <= cmd.out_ovf;
        end
    end

    assign grad_out     = grad_out_reg;
    assign last_out     = last_out_reg;
    assign row_overflow = row_overflow_reg;

endmodule

`default_nettype wire

@@ hdl/softmax_row_gradient_unit.sv @@
// Top level of the softmax row gradient unit: controller plus datapath.
// Uses smrg_pkg, smrg_ctrl, smrg_dp.
//
//   channel   valid      stall      payload
//   input     in_valid   in_stall   prob, grad_in, row_end
//   output    out_valid  out_stall  grad_out, last_out, row_overflow
//
// While a row loads, one element is taken every cycle.
// After the row end, a drain state finishes the dot product; each stored
// element then passes through the store read, difference, split multiply,
// rounding sum and saturation, and is held while the output stalls.
// The input stalls from the row end until the last result enters the output register.
// Reset is asynchronous and active low; the store itself is not cleared.
`default_nettype none

module softmax_row_gradient_unit
    import smrg_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [PROB_W-1:0]        prob,
    input  wire logic signed [GRAD_W-1:0] grad_in,
    input  wire logic                     row_end,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [GRAD_W-1:0]      grad_out,
    output logic                          last_out,
    output logic                          row_overflow
);

    cmd_t cmd;

    smrg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .row_end   (row_end),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    smrg_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .prob         (prob),
        .grad_in      (grad_in),
        .grad_out     (grad_out),
        .last_out     (last_out),
        .row_overflow (row_overflow)
    );

endmodule

`default_nettype wire
